### hdl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared types and constants for the modular exponentiation unit.
// ----------------------------------------------------------------------------
package mexp_pkg;

   // Width of the payload and register ports
   localparam int unsigned PORT_W = 32;

   // Modulus value after reset
   localparam logic [PORT_W-1:0] MODULUS_RESET = 32'd97;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_ISSUE,
      ST_WAIT
   } fsm_state_type;

endpackage

### hdl/modular_exponentiation_unit.sv
// ----------------------------------------------------------------------------
// Modular exponentiation unit
// Right-to-left square-and-multiply of base^exponent mod a set modulus.
// ----------------------------------------------------------------------------
// Usage:
//   Write the modulus through csr_we/csr_wdata while busy is low.
//   A transaction is taken when start is high and busy is low; base and
//   exponent are sampled then. busy stays high until the result is shown.
//   The result appears on rsp_power for one cycle with rsp_valid high;
//   the receiver cannot stall it and must take it in that cycle.
// Operation:
//   The exponent sits in a row of bit cells that shifts one place per
//   exponent step. Each step runs the multiply and the square side by side
//   in two bit-serial modular multipliers: an issue state starts both, and
//   a wait state holds until the square unit is done. When the modulus is
//   nonzero, the base is first reduced in the multiply unit. busy stays high
//   through that reduction, one step per exponent bit up to the highest set
//   one, and a final issue state; rsp_valid rises in the first cycle with
//   busy low.
// Reset:
//   Synchronous, active high; returns to idle and sets the modulus to 97.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit #(
   parameter int unsigned WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [mexp_pkg::PORT_W-1:0]   req_base,
   input  logic [mexp_pkg::PORT_W-1:0]   req_exponent,
   output logic                          rsp_valid,
   output logic [mexp_pkg::PORT_W-1:0]   rsp_power,
   input  logic                          csr_we,
   input  logic [mexp_pkg::PORT_W-1:0]   csr_wdata
);
   import mexp_pkg::*;

   fsm_state_type     state_ff, state_in;
   logic [WIDTH-1:0]  mod_ff, mod_in;
   logic [WIDTH-1:0]  base_ff, base_in;
   logic [WIDTH-1:0]  res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PORT_W-1:0] rsp_power_ff, rsp_power_in;

   logic              mul_start, sq_start;
   logic [WIDTH-1:0]  mul_a, mul_b;
   logic              mul_done, sq_done;
   logic [WIDTH-1:0]  mul_p, sq_p;

   logic              cell_load, cell_shift;
   logic [WIDTH-1:0]  exp_load;
   logic [WIDTH:0]    exp_chain;

   assign exp_load = WIDTH'(req_exponent);

   // Exponent row: each cell hands its bit down one place per step
   assign exp_chain[WIDTH] = 1'b0;
   for (genvar i = 0; i < WIDTH; i++) begin : g_cell
      mexp_cell u_cell (
         .clock    (clock),
         .load     (cell_load),
         .shift    (cell_shift),
         .load_bit (exp_load[i]),
         .next_bit (exp_chain[i+1]),
         .bit_out  (exp_chain[i])
      );
   end

   // Multiply unit: base reduction, then result times base
   mexp_modmul #(.WIDTH(WIDTH)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .modulus (mod_ff),
      .done    (mul_done),
      .product (mul_p)
   );

   // Square unit: base times base
   mexp_modmul #(.WIDTH(WIDTH)) u_sq (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .op_a    (base_ff),
      .op_b    (base_ff),
      .modulus (mod_ff),
      .done    (sq_done),
      .product (sq_p)
   );

   // Sequence the reduction and the exponent steps
   always_comb begin
      state_in     = state_ff;
      mod_in       = mod_ff;
      base_in      = base_ff;
      res_in       = res_ff;
      rsp_valid_in = 1'b0;
      rsp_power_in = rsp_power_ff;
      mul_start    = 1'b0;
      sq_start     = 1'b0;
      mul_a        = res_ff;
      mul_b        = base_ff;
      cell_load    = 1'b0;
      cell_shift   = 1'b0;
      if (csr_we) begin
         mod_in = WIDTH'(csr_wdata);
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cell_load = 1'b1;
               base_in   = WIDTH'(req_base);
               res_in    = WIDTH'(1);
               if (mod_ff != '0) begin
                  mul_start = 1'b1;
                  mul_a     = WIDTH'(1);
                  mul_b     = WIDTH'(req_base);
                  state_in  = ST_REDUCE;
               end else begin
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_REDUCE: begin
            if (mul_done) begin
               base_in  = mul_p;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (exp_chain[WIDTH-1:0] == '0) begin
               rsp_valid_in = 1'b1;
               rsp_power_in = PORT_W'(res_ff);
               state_in     = ST_IDLE;
            end else begin
               mul_start = 1'b1;
               sq_start  = 1'b1;
               state_in  = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (sq_done) begin
               if (exp_chain[0]) begin
                  res_in = mul_p;
               end
               base_in    = sq_p;
               cell_shift = 1'b1;
               state_in   = ST_ISSUE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mod_ff       <= WIDTH'(MODULUS_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mod_ff       <= mod_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff      <= base_in;
      res_ff       <= res_in;
      rsp_power_ff <= rsp_power_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_power = rsp_power_ff;

endmodule

### hdl/mexp_cell.sv
// ----------------------------------------------------------------------------
// Exponent bit cell
// Holds one exponent bit; on a shift it takes the bit of its upper neighbor.
// ----------------------------------------------------------------------------
module mexp_cell (
   input  logic clock,
   input  logic load,
   input  logic shift,
   input  logic load_bit,
   input  logic next_bit,
   output logic bit_out
);
   logic bit_ff;
   logic bit_in;

   // Load a fresh bit or take the neighbor's bit
   always_comb begin
      bit_in = bit_ff;
      if (load) begin
         bit_in = load_bit;
      end else if (shift) begin
         bit_in = next_bit;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
   end

   assign bit_out = bit_ff;

endmodule

### hdl/mexp_modmul.sv
// ----------------------------------------------------------------------------
// Modular multiplier
// Interleaved double-and-add, one multiplier bit per cycle, MSB first.
// A modulus of zero wraps the product at WIDTH bits.
// ----------------------------------------------------------------------------
module mexp_modmul #(
   parameter int unsigned WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_b,
   input  logic [WIDTH-1:0] modulus,
   output logic             done,
   output logic [WIDTH-1:0] product
);
   localparam int unsigned CNT_W = $clog2(WIDTH + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [WIDTH-1:0] m_ff, m_in;
   logic [WIDTH-1:0] dbl;

   // (x + y) mod m for x, y below m; m of zero wraps
   function automatic logic [WIDTH-1:0] add_mod(
      input logic [WIDTH-1:0] x,
      input logic [WIDTH-1:0] y,
      input logic [WIDTH-1:0] m
   );
      logic [WIDTH:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (m != '0 && s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[WIDTH-1:0];
   endfunction

   // Double, conditionally add, advance one multiplier bit
   always_comb begin
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      dbl     = add_mod(acc_ff, acc_ff, m_ff);
      if (start) begin
         cnt_in = CNT_W'(WIDTH);
         run_in = 1'b1;
         acc_in = '0;
         a_in   = op_a;
         b_in   = op_b;
         m_in   = modulus;
      end else if (run_ff) begin
         acc_in = b_ff[WIDTH-1] ? add_mod(dbl, a_ff, m_ff) : dbl;
         b_in   = {b_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule
